// ----- rtl/assert_macros.svh -----
// assertion macros shared by the allocator rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("allocator assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("allocator condition must not occur");

`endif

// ----- rtl/ffsa_pkg.sv -----
// shared types and constants of the first-fit split allocator
// no dependencies
package ffsa_pkg;

   localparam int START_W = 16;
   localparam int SIZE_W  = 17;
   localparam int LINK_W  = 11;

   localparam int DEF_REGION_PAGES = 16;
   localparam int DEF_PAGE_BYTES   = 4096;
   localparam int DEF_HEADER_BYTES = 24;
   localparam int DEF_MAX_BLOCKS   = 1024;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic [START_W-1:0] start;
      logic [SIZE_W-1:0]  size;
      logic               free;
      logic [LINK_W-1:0]  link;
   } entry_type;

endpackage

// ----- rtl/ffsa_mem.sv -----
// block descriptor memory, one write and one registered read per cycle
// depends on ffsa_pkg; entry 0 reads as its reset value until written
module ffsa_mem import ffsa_pkg::*; #(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
   parameter int HEAD_SIZE  = DEF_REGION_PAGES * DEF_PAGE_BYTES - DEF_HEADER_BYTES,
   localparam int IDX_W     = $clog2(MAX_BLOCKS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data
);

   entry_type mem [MAX_BLOCKS];
   entry_type rd_raw_ff;
   logic      rd_zero_ff;
   logic      head_written_ff;
   entry_type head_init;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff  <= mem[rd_addr];
         rd_zero_ff <= (rd_addr == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_written_ff <= 1'b0;
      end else if (wr_en && wr_addr == '0) begin
         head_written_ff <= 1'b1;
      end
   end

   always_comb begin
      head_init.start = '0;
      head_init.size  = SIZE_W'(HEAD_SIZE);
      head_init.free  = 1'b1;
      head_init.link  = '0;
   end

   // untouched head entry comes from its reset value
   assign rd_data = (rd_zero_ff && !head_written_ff) ? head_init : rd_raw_ff;

endmodule

// ----- rtl/first_fit_split_allocator.sv -----
// first-fit allocator: the walk runs in the LOOK state, a block split then passes through SPLIT,
// and DONE loads the result into the output register; the next transaction is taken back in IDLE
// the walk reads one descriptor per cycle from the descriptor memory
// one transaction at a time; the walk visits at most MAX_BLOCKS entries per transaction
// a finished result waits in the output register while the next transaction is taken
// reset clears control state and marks entry 0 as its initial whole-region free block;
// no memory clearing pass, the block is ready the cycle after reset
module first_fit_split_allocator import ffsa_pkg::*; #(
   parameter int REGION_PAGES = DEF_REGION_PAGES,
   parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES,
   parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [SIZE_W-1:0]  req_alloc_size,
   input  logic [START_W-1:0] req_release_offset,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_success,
   output logic [START_W-1:0] rsp_data_offset
);
   `include "assert_macros.svh"

   localparam int IDX_W     = $clog2(MAX_BLOCKS);
   localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
   localparam int HEAD_SIZE = REGION_PAGES * PAGE_BYTES - HEADER_BYTES;

   typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_SPLIT, ST_DONE} state_type;

   state_type          state_ff;
   logic               cmd_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [START_W-1:0] off_ff;
   logic [IDX_W-1:0]   cur_ff;
   logic [IDX_W-1:0]   steps_ff;
   logic [CNT_W-1:0]   used_ff;
   entry_type          hold_ff;
   logic               res_ok_ff;
   logic [START_W-1:0] res_off_ff;
   logic               rsp_valid_ff;
   logic               rsp_success_ff;
   logic [START_W-1:0] rsp_offset_ff;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   entry_type          ent;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;

   logic               accept;
   logic               fit;
   logic [SIZE_W-1:0]  rem;
   logic               split;
   logic               hit;
   logic               last;
   logic [START_W-1:0] data_off;
   entry_type          new_ent;
   entry_type          upd_ent;
   logic               out_free;

   ffsa_mem #(
      .MAX_BLOCKS(MAX_BLOCKS),
      .HEAD_SIZE (HEAD_SIZE)
   ) u_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ent),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      fit      = ent.free && (ent.size >= size_ff);
      rem      = ent.size - size_ff;
      split    = (rem > SIZE_W'(HEADER_BYTES)) && (used_ff < CNT_W'(MAX_BLOCKS));
      hit      = (off_ff != '0) &&
                 (({1'b0, ent.start} + SIZE_W'(HEADER_BYTES)) == {1'b0, off_ff});
      last     = (ent.link == '0) || (steps_ff == IDX_W'(MAX_BLOCKS - 1));
      data_off = START_W'(ent.start + START_W'(HEADER_BYTES));

      new_ent.start = START_W'(ent.start + START_W'(HEADER_BYTES) + size_ff[START_W-1:0]);
      new_ent.size  = rem - SIZE_W'(HEADER_BYTES);
      new_ent.free  = 1'b1;
      new_ent.link  = ent.link;

      upd_ent = ent;
      if (cmd_ff == CMD_FREE) begin
         upd_ent.free = 1'b1;
      end else begin
         upd_ent.free = 1'b0;
         if (split) begin
            upd_ent.size = size_ff;
            upd_ent.link = LINK_W'(used_ff[IDX_W-1:0]);
         end
      end

      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = cur_ff;
      wr_data = upd_ent;
      unique case (state_ff)
         ST_IDLE: begin
            rd_en = accept;
         end
         ST_LOOK: begin
            if (cmd_ff == CMD_FREE ? hit : fit) begin
               wr_en = 1'b1;
               if (cmd_ff == CMD_ALLOC && split) begin
                  wr_addr = used_ff[IDX_W-1:0];
                  wr_data = new_ent;
               end
            end else if (!last) begin
               rd_en   = 1'b1;
               rd_addr = ent.link[IDX_W-1:0];
            end
         end
         ST_SPLIT: begin
            wr_en   = 1'b1;
            wr_data = hold_ff;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff   <= req_command;
                  size_ff  <= req_alloc_size;
                  off_ff   <= req_release_offset;
                  cur_ff   <= '0;
                  steps_ff <= '0;
                  state_ff <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               if (cmd_ff == CMD_FREE ? hit : fit) begin
                  res_ok_ff  <= 1'b1;
                  res_off_ff <= (cmd_ff == CMD_FREE) ? '0 : data_off;
                  if (cmd_ff == CMD_ALLOC && split) begin
                     hold_ff  <= upd_ent;
                     used_ff  <= used_ff + CNT_W'(1);
                     state_ff <= ST_SPLIT;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end else if (last) begin
                  res_ok_ff  <= 1'b0;
                  res_off_ff <= '0;
                  state_ff   <= ST_DONE;
               end else begin
                  cur_ff   <= ent.link[IDX_W-1:0];
                  steps_ff <= steps_ff + IDX_W'(1);
               end
            end
            ST_SPLIT: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_success_ff <= res_ok_ff;
                  rsp_offset_ff  <= res_off_ff;
                  state_ff       <= ST_IDLE;
               end else if (rsp_valid_ff && !rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = rsp_success_ff;
   assign rsp_data_offset = rsp_offset_ff;

   `ASSERT_NEVER(a_used_bound, clock, reset, used_ff > CNT_W'(MAX_BLOCKS) || used_ff == '0)
   `ASSERT_CLK(a_used_only_on_split, clock, reset, (state_ff != ST_LOOK) |=> $stable(used_ff))
   `ASSERT_CLK(a_split_after_look, clock, reset,
      (state_ff == ST_SPLIT) |-> ($past(state_ff) == ST_LOOK && cmd_ff == CMD_ALLOC))

endmodule

// ----- dv/first_fit_split_allocator_checker.sv -----
// checker for the first-fit split allocator: watches both channels, predicts, compares
// depends on ffsa_pkg for widths and command codes
`timescale 1ns / 100ps
module first_fit_split_allocator_checker import ffsa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_command,
   input  logic [SIZE_W-1:0]  req_alloc_size,
   input  logic [START_W-1:0] req_release_offset,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_success,
   input  logic [START_W-1:0] rsp_data_offset,
   output int                 error_count,
   output int                 pending_count,
   output int                 accept_count,
   output int                 splits_seen,
   output int                 table_full_seen
);
   localparam int HDR     = DEF_HEADER_BYTES;
   localparam int NBLK    = DEF_MAX_BLOCKS;
   localparam int REGION  = DEF_REGION_PAGES * DEF_PAGE_BYTES;

   typedef struct packed {
      logic               success;
      logic [START_W-1:0] offset;
   } outcome_type;

   logic [START_W-1:0] blk_start [NBLK];
   logic [SIZE_W-1:0]  blk_size  [NBLK];
   logic               blk_free  [NBLK];
   logic [LINK_W-1:0]  blk_link  [NBLK];
   int                 blk_count;
   outcome_type        expected_outcomes [$];

   function automatic outcome_type heap_allocate(input logic [SIZE_W-1:0] want);
      outcome_type r;
      int i, n, steps;
      logic [SIZE_W-1:0] rest;
      i = 0;
      r = '0;
      for (steps = 0; steps < NBLK; steps++) begin
         if (blk_free[i] && blk_size[i] >= want) begin
            rest = blk_size[i] - want;
            if (rest > HDR && blk_count < NBLK) begin
               n = blk_count;
               blk_start[n] = START_W'(blk_start[i] + HDR + want);
               blk_size[n]  = rest - HDR;
               blk_free[n]  = 1'b1;
               blk_link[n]  = blk_link[i];
               blk_size[i]  = want;
               blk_link[i]  = LINK_W'(n);
               blk_count    = n + 1;
               splits_seen++;
            end else if (blk_count == NBLK) begin
               table_full_seen++;
            end
            blk_free[i] = 1'b0;
            r.success = 1'b1;
            r.offset  = START_W'(blk_start[i] + HDR);
            return r;
         end
         if (blk_link[i] == 0) break;
         i = blk_link[i];
      end
      return r;
   endfunction

   function automatic outcome_type heap_release(input logic [START_W-1:0] off);
      outcome_type r;
      int i, steps;
      i = 0;
      r = '0;
      if (off == 0) return r;
      for (steps = 0; steps < NBLK; steps++) begin
         if (32'(blk_start[i]) + HDR == 32'(off)) begin
            blk_free[i] = 1'b1;
            r.success = 1'b1;
            return r;
         end
         if (blk_link[i] == 0) break;
         i = blk_link[i];
      end
      return r;
   endfunction

   assign pending_count = expected_outcomes.size();

   always @(posedge clock) begin
      outcome_type got, exp_o;
      if (reset) begin
         for (int k = 0; k < NBLK; k++) begin
            blk_start[k] = '0; blk_size[k] = '0; blk_free[k] = 1'b0; blk_link[k] = '0;
         end
         blk_size[0]  = SIZE_W'(REGION - HDR);
         blk_free[0]  = 1'b1;
         blk_count    = 1;
         error_count  = 0;
         accept_count = 0;
         splits_seen  = 0;
         table_full_seen = 0;
         expected_outcomes.delete();
      end else begin
         // result side first: a transaction taken this edge cannot already be answered
         if (rsp_valid && !rsp_stall) begin
            got.success = rsp_success;
            got.offset  = rsp_data_offset;
            if (expected_outcomes.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: unexpected result success=%0b offset=%0d",
                           got.success, got.offset);
            end else begin
               exp_o = expected_outcomes.pop_front();
               if (got !== exp_o) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: expected success=%0b offset=%0d got success=%0b offset=%0d",
                              exp_o.success, exp_o.offset, got.success, got.offset);
               end
            end
         end
         if (req_valid && !req_stall) begin
            accept_count++;
            if (req_command == CMD_ALLOC)
               expected_outcomes.push_back(heap_allocate(req_alloc_size));
            else
               expected_outcomes.push_back(heap_release(req_release_offset));
         end
      end
   end
endmodule

// ----- dv/first_fit_split_allocator_tb.sv -----
// stimulus and verdict for the first-fit split allocator
// depends on ffsa_pkg, the allocator rtl and first_fit_split_allocator_checker
`timescale 1ns / 100ps
module first_fit_split_allocator_tb;
   import ffsa_pkg::*;

   localparam int WATCHDOG = 200000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_command = CMD_ALLOC;
   logic [SIZE_W-1:0]  req_alloc_size = '0;
   logic [START_W-1:0] req_release_offset = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_success;
   logic [START_W-1:0] rsp_data_offset;
   int error_count, pending_count, accept_count, splits_seen, table_full_seen;

   int  send_idle_pct = 13;
   int  recv_idle_pct = 56;
   bit  hold_rsp = 1'b0;
   int  idle_cycles = 0;
   logic [START_W-1:0] granted [$];

   always #10 clock = ~clock;

   first_fit_split_allocator dut (.*);

   first_fit_split_allocator_checker checker_i (.*);

   // receiver: random stall, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
   end

   // record granted offsets so frees mostly hit real blocks
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp_success && rsp_data_offset != 0)
         granted.push_back(rsp_data_offset);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // valid stays high after the accepting edge; the caller drops it when done
   task automatic send(input logic cmd, input logic [SIZE_W-1:0] sz,
                       input logic [START_W-1:0] off);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_alloc_size <= sz;
      req_release_offset <= off;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_item();
      int pick, k;
      logic [START_W-1:0] off;
      pick = $urandom_range(99);
      if (pick < 55) begin
         // mostly small sizes so the table fills, occasional big or extreme
         if ($urandom_range(9) < 8) send(CMD_ALLOC, SIZE_W'($urandom_range(64)), '0);
         else send(CMD_ALLOC, SIZE_W'($urandom_range(17'h1FFFF)), '0);
      end else if (pick < 90 && granted.size() > 0) begin
         k = $urandom_range(granted.size() - 1);
         off = granted[k];
         if ($urandom_range(3) != 0) granted.delete(k);   // else a later double free
         send(CMD_FREE, SIZE_W'($urandom), off);
      end else begin
         send(CMD_FREE, SIZE_W'($urandom), START_W'($urandom));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero size, exact fit, null, unknown, double free, oversize
      send(CMD_ALLOC, 17'd0, '0);
      send(CMD_ALLOC, 17'd100, 16'hFFFF);
      send(CMD_FREE, 17'h1FFFF, 16'd0);
      send(CMD_FREE, '0, 16'd25);
      send(CMD_FREE, '0, 16'hFFFF);
      send(CMD_FREE, '0, 16'd24);
      send(CMD_FREE, '0, 16'd24);
      send(CMD_ALLOC, 17'h1FFFF, '0);
      send(CMD_ALLOC, 17'd65536, '0);
      send(CMD_ALLOC, 17'd0, '0);
      send(CMD_ALLOC, 17'd40, '0);
      send(CMD_FREE, '0, 16'd48);
      send(CMD_ALLOC, 17'd24, '0);
      send(CMD_ALLOC, 17'd30000, '0);
      send(CMD_ALLOC, 17'd35000, '0);
      send(CMD_ALLOC, 17'd20, '0);
      req_valid <= 1'b0;
      drain();

      // long receiver hold-off while the sender keeps offering
      hold_rsp = 1'b1;
      fork
         begin repeat (300) @(posedge clock); hold_rsp = 1'b0; end
         begin repeat (6) random_item(); req_valid <= 1'b0; end
      join
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin send_idle_pct = 56; recv_idle_pct = 13; end
         if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         for (int n = 0; n < 186; n++) random_item();
         req_valid <= 1'b0;
         drain();
      end

      $display("covered %0d transactions, %0d block splits, %0d table-full grants",
               accept_count, splits_seen, table_full_seen);
      if (error_count == 0 && pending_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
